// File: hw/rtl/mcbd_pkg.sv
// ----------------------------------------------------------------------------
// mcbd_pkg
// Shared constants and types of the mip chain box downsampler.
// ----------------------------------------------------------------------------
package mcbd_pkg;

  localparam int MAX_DIM_LOG2 = 10;
  localparam int CHANNELS     = 4;
  localparam int NUM_SLOTS    = 4;
  localparam int CH_W         = 8;
  localparam int SUM_W        = CH_W + 1;
  localparam int DIM_W        = 10;
  localparam int LOG2_W       = 4;
  localparam int LVL_W        = 4;
  localparam int LINE_DEPTH   = 1 << MAX_DIM_LOG2;
  localparam int LINE_AW      = MAX_DIM_LOG2;
  localparam int LINE_DW      = NUM_SLOTS * SUM_W;
  localparam int CFG_IDX_W    = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_LOG2  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_LOG2 = 2'd1;

  localparam logic [LOG2_W-1:0] RESET_DIM_LOG2 = 4'd6;

  typedef logic [NUM_SLOTS-1:0][CH_W-1:0]  pixel_t;
  typedef logic [NUM_SLOTS-1:0][SUM_W-1:0] pair_sum_t;

endpackage

// File: hw/rtl/mcbd_ram.sv
// ----------------------------------------------------------------------------
// mcbd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mcbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/mcbd_lane.sv
// ----------------------------------------------------------------------------
// mcbd_lane
// One channel lane: horizontal pair sum and 2x2 truncated mean.
// ----------------------------------------------------------------------------
module mcbd_lane (
  input  logic [mcbd_pkg::CH_W-1:0]  px_i,
  input  logic [mcbd_pkg::CH_W-1:0]  left_i,
  input  logic [mcbd_pkg::SUM_W-1:0] top_i,
  output logic [mcbd_pkg::SUM_W-1:0] pair_o,
  output logic [mcbd_pkg::CH_W-1:0]  avg_o
);

  logic [mcbd_pkg::SUM_W:0] quad;

  assign pair_o = mcbd_pkg::SUM_W'(left_i) + mcbd_pkg::SUM_W'(px_i);
  assign quad   = (mcbd_pkg::SUM_W+1)'(top_i) + (mcbd_pkg::SUM_W+1)'(pair_o);
  assign avg_o  = quad[mcbd_pkg::SUM_W:2];

endmodule

// File: hw/rtl/mip_chain_box_downsampler.sv
// ----------------------------------------------------------------------------
// mip_chain_box_downsampler
// Streaming 2x2 box-filter mip chain generator for RGBA8 raster input.
// ----------------------------------------------------------------------------
// A request is registered in the level sequencer, then each of its results
//   (1 to n+1) in the output register. Throughput: the level sequencer
//   handles one level per cycle unless the output stalls, bounded by the
//   single output register and the one read port of the pair-sum line store.
// Reset: sync active low; clears counters, sizes (6/6) and valids; the line
//   stores are not cleared and hold nothing meaningful until written.
// ----------------------------------------------------------------------------
module mip_chain_box_downsampler (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [mcbd_pkg::CH_W-1:0]         in_red,
  input  logic [mcbd_pkg::CH_W-1:0]         in_green,
  input  logic [mcbd_pkg::CH_W-1:0]         in_blue,
  input  logic [mcbd_pkg::CH_W-1:0]         in_alpha,
  input  logic                              in_frame_start,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mcbd_pkg::LVL_W-1:0]        out_level,
  output logic [mcbd_pkg::DIM_W-1:0]        out_pixel_x,
  output logic [mcbd_pkg::DIM_W-1:0]        out_pixel_y,
  output logic [mcbd_pkg::CH_W-1:0]         out_red,
  output logic [mcbd_pkg::CH_W-1:0]         out_green,
  output logic [mcbd_pkg::CH_W-1:0]         out_blue,
  output logic [mcbd_pkg::CH_W-1:0]         out_alpha,
  output logic                              out_last_of_run,
  output logic                              out_last_of_image,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mcbd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mcbd_pkg::LOG2_W-1:0]       cfg_data
);

  localparam int DW = mcbd_pkg::DIM_W;
  localparam int EW = mcbd_pkg::DIM_W + 1;

  function automatic logic [mcbd_pkg::LINE_AW-1:0] line_idx(
    input logic [mcbd_pkg::LOG2_W-1:0] wl,
    input logic [mcbd_pkg::LVL_W-1:0]  lvl,
    input logic [DW-1:0]               x
  );
    logic [EW-1:0] start;
    start = (EW'(1) << wl) - (EW'(1) << (wl - lvl));
    return mcbd_pkg::LINE_AW'(start + EW'(x >> 1));
  endfunction

  // configuration
  logic [mcbd_pkg::LOG2_W-1:0] wl_r, hl_r, wl_nxt, hl_nxt, cfg_sat, n_lvl;
  logic [DW-1:0] wmask, hmask;

  // base raster counters
  logic [DW-1:0] base_col_r, base_row_r, base_col_nxt, base_row_nxt;
  logic [DW-1:0] col_in, row_in;

  // level sequencer
  logic                         busy_r, busy_nxt;
  logic [DW-1:0]                col_r, row_r, col_nxt, row_nxt;
  logic [mcbd_pkg::LVL_W-1:0]   lvl_r, lvl_nxt;
  mcbd_pkg::pixel_t             px_r, px_nxt, px_in, left_q, avg;
  logic                         img_end_r, img_end_nxt;
  logic [DW-1:0]                x_cur, y_cur;
  logic                         at_top, done_now, adv, step, accept;
  mcbd_pkg::pixel_t             left_pixel_r [mcbd_pkg::MAX_DIM_LOG2];
  mcbd_pkg::pair_sum_t          pair, top_q;

  // line store
  logic                         ram_we, ram_re;
  logic [mcbd_pkg::LINE_AW-1:0] ram_waddr, ram_raddr;
  logic [mcbd_pkg::LINE_DW-1:0] ram_q;

  // output register
  logic                         out_valid_r, out_valid_nxt;
  logic [mcbd_pkg::LVL_W-1:0]   out_level_r, out_level_nxt;
  logic [DW-1:0]                out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  mcbd_pkg::pixel_t             out_px_r, out_px_nxt;
  logic                         out_lrun_r, out_lrun_nxt, out_limg_r, out_limg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg_sat   = (cfg_data > mcbd_pkg::LOG2_W'(mcbd_pkg::MAX_DIM_LOG2))
                   ? mcbd_pkg::LOG2_W'(mcbd_pkg::MAX_DIM_LOG2) : cfg_data;

  always_comb begin
    wl_nxt = wl_r;
    hl_nxt = hl_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mcbd_pkg::REG_WIDTH_LOG2:  wl_nxt = cfg_sat;
        mcbd_pkg::REG_HEIGHT_LOG2: hl_nxt = cfg_sat;
        default: ;
      endcase
    end
  end

  assign wmask = DW'((EW'(1) << wl_r) - EW'(1));
  assign hmask = DW'((EW'(1) << hl_r) - EW'(1));
  assign n_lvl = (wl_r < hl_r) ? wl_r : hl_r;

  // current level of the item in flight
  assign x_cur    = col_r >> lvl_r;
  assign y_cur    = row_r >> lvl_r;
  assign at_top   = (lvl_r >= n_lvl);
  assign done_now = at_top || !x_cur[0] || !y_cur[0];

  assign adv      = !out_valid_r || !out_stall;
  assign step     = busy_r && adv;
  assign in_stall = busy_r && !(step && done_now);
  assign accept   = in_valid && !in_stall;

  assign col_in = in_frame_start ? '0 : (base_col_r & wmask);
  assign row_in = in_frame_start ? '0 : (base_row_r & hmask);
  assign px_in  = {in_alpha, in_blue, in_green, in_red};

  always_comb begin
    for (int i = 0; i < mcbd_pkg::NUM_SLOTS; i++) begin
      left_q[i] = '0;
    end
    if (lvl_r < mcbd_pkg::LVL_W'(mcbd_pkg::MAX_DIM_LOG2)) begin
      left_q = left_pixel_r[lvl_r];
    end
  end

  assign top_q = mcbd_pkg::pair_sum_t'(ram_q);

  // one lane per channel; unused channels read as zero
  for (genvar c = 0; c < mcbd_pkg::NUM_SLOTS; c++) begin : g_lane
    if (c < mcbd_pkg::CHANNELS) begin : g_on
      mcbd_lane u_lane (
        .px_i  (px_r[c]),
        .left_i(left_q[c]),
        .top_i (top_q[c]),
        .pair_o(pair[c]),
        .avg_o (avg[c])
      );
    end else begin : g_off
      assign pair[c] = '0;
      assign avg[c]  = '0;
    end
  end

  // line store access: write on an upper row, prefetch the next level's entry
  assign ram_we    = step && !at_top && x_cur[0] && !y_cur[0];
  assign ram_waddr = line_idx(wl_r, lvl_r, x_cur);
  assign ram_re    = accept || (step && !done_now);
  assign ram_raddr = accept ? line_idx(wl_r, '0, col_in)
                            : line_idx(wl_r, lvl_r + 1'b1, x_cur >> 1);

  mcbd_ram #(
    .WIDTH(mcbd_pkg::LINE_DW),
    .DEPTH(mcbd_pkg::LINE_DEPTH)
  ) u_line (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(mcbd_pkg::LINE_DW'(pair)),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_q)
  );

  always_comb begin
    busy_nxt      = busy_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    lvl_nxt       = lvl_r;
    px_nxt        = px_r;
    img_end_nxt   = img_end_r;
    base_col_nxt  = base_col_r;
    base_row_nxt  = base_row_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_level_nxt = out_level_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_px_nxt    = out_px_r;
    out_lrun_nxt  = out_lrun_r;
    out_limg_nxt  = out_limg_r;

    if (step) begin
      out_valid_nxt = 1'b1;
      out_level_nxt = lvl_r;
      out_x_nxt     = x_cur;
      out_y_nxt     = y_cur;
      out_px_nxt    = px_r;
      out_lrun_nxt  = done_now;
      out_limg_nxt  = done_now && img_end_r;
      if (done_now) begin
        busy_nxt = 1'b0;
      end else begin
        lvl_nxt = lvl_r + 1'b1;
        px_nxt  = avg;
      end
    end

    if (accept) begin
      busy_nxt    = 1'b1;
      col_nxt     = col_in;
      row_nxt     = row_in;
      lvl_nxt     = '0;
      px_nxt      = px_in;
      img_end_nxt = (col_in == wmask) && (row_in == hmask);
      // advance raster position, wrap at end of row and image
      if (col_in == wmask) begin
        base_col_nxt = '0;
        base_row_nxt = (row_in + 1'b1) & hmask;
      end else begin
        base_col_nxt = col_in + 1'b1;
        base_row_nxt = row_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r        <= mcbd_pkg::RESET_DIM_LOG2;
      hl_r        <= mcbd_pkg::RESET_DIM_LOG2;
      base_col_r  <= '0;
      base_row_r  <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wl_r        <= wl_nxt;
      hl_r        <= hl_nxt;
      base_col_r  <= base_col_nxt;
      base_row_r  <= base_row_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
    col_r       <= col_nxt;
    row_r       <= row_nxt;
    lvl_r       <= lvl_nxt;
    px_r        <= px_nxt;
    img_end_r   <= img_end_nxt;
    out_level_r <= out_level_nxt;
    out_x_r     <= out_x_nxt;
    out_y_r     <= out_y_nxt;
    out_px_r    <= out_px_nxt;
    out_lrun_r  <= out_lrun_nxt;
    out_limg_r  <= out_limg_nxt;
  end

  // hold the left pixel of a pending horizontal pair
  always_ff @(posedge clk) begin
    if (step && !at_top && !x_cur[0]) begin
      left_pixel_r[lvl_r] <= px_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_level         = out_level_r;
  assign out_pixel_x       = out_x_r;
  assign out_pixel_y       = out_y_r;
  assign out_red           = out_px_r[0];
  assign out_green         = out_px_r[1];
  assign out_blue          = out_px_r[2];
  assign out_alpha         = out_px_r[3];
  assign out_last_of_run   = out_lrun_r;
  assign out_last_of_image = out_limg_r;

endmodule
